// ----- sv/asbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbc_pkg
// shared types, constants and field arithmetic for the computed aes s-box
// ----------------------------------------------------------------------------
package asbc_pkg;

  localparam logic [7:0] PolyLow  = 8'h1b;
  localparam logic [7:0] FwdConst = 8'h63;
  localparam logic [7:0] InvConst = 8'h05;
  localparam logic [7:0] OneElem  = 8'h01;

  // seven square-and-multiply rounds build a^254 (exponent bits 1..7)
  localparam int unsigned NumRounds = 7;
  localparam int unsigned RoundW    = $clog2(NumRounds);
  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);

  typedef struct packed {
    logic load;
    logic square;
    logic mult;
    logic finish;
  } asbc_cmd_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ PolyLow) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int unsigned n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] affine_fwd(input logic [7:0] x);
    return x ^ rotl(x, 1) ^ rotl(x, 2) ^ rotl(x, 3) ^ rotl(x, 4) ^ FwdConst;
  endfunction

  function automatic logic [7:0] affine_inv(input logic [7:0] x);
    return rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ InvConst;
  endfunction

endpackage

// ----- sv/asbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbc_ctrl
// sequencer for the square-and-multiply inversion rounds
// ----------------------------------------------------------------------------
module asbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output asbc_pkg::asbc_cmd_t cmd_o
);
  import asbc_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSquare = 4'b0010,
    StMult   = 4'b0100,
    StDone   = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [RoundW-1:0]   round_q, round_d;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          round_d    = '0;
          state_d    = StSquare;
        end
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        state_d      = StMult;
      end
      StMult: begin
        cmd_o.mult = 1'b1;
        if (round_q == LastRound) begin
          state_d = StDone;
        end else begin
          round_d = round_q + RoundW'(1);
          state_d = StSquare;
        end
      end
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

endmodule

// ----- sv/asbc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbc_dpath
// base and accumulator registers around one shared gf(2^8) multiplier
// ----------------------------------------------------------------------------
module asbc_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asbc_pkg::asbc_cmd_t cmd_i,
  input  logic                inverse_mode_i,
  input  logic [7:0]          in_byte_i,
  output logic [7:0]          out_byte_o,
  output logic                valid_o
);
  import asbc_pkg::*;

  logic [7:0] base_q, base_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] out_q, out_d;
  logic       valid_q;
  logic [7:0] mul_a, mul_b, mul_p;

  // one multiplier: squares the base or folds it into the accumulator
  assign mul_a = cmd_i.mult ? acc_q : base_q;
  assign mul_b = base_q;
  assign mul_p = gf_mul(mul_a, mul_b);

  always_comb begin
    base_d = base_q;
    acc_d  = acc_q;
    out_d  = out_q;
    if (cmd_i.load) begin
      base_d = inverse_mode_i ? affine_inv(in_byte_i) : in_byte_i;
      acc_d  = OneElem;
    end
    if (cmd_i.square) base_d = mul_p;
    if (cmd_i.mult)   acc_d  = mul_p;
    if (cmd_i.finish) out_d  = inverse_mode_i ? acc_q : affine_fwd(acc_q);
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= cmd_i.finish;
  end

  assign out_byte_o = out_q;
  assign valid_o    = valid_q;

endmodule

// ----- sv/aes_sbox_byte_compute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_sbox_byte_compute
// computed aes s-box: gf(2^8) inverse plus affine transform, one byte a request
// ----------------------------------------------------------------------------
// usage
// - request channel: drive in_byte_i and raise start; the request is taken at
//   a clock edge where start is high and busy is low
// - result channel: out_byte_o is valid for exactly one cycle while valid_o is
//   high; the receiver cannot stall, so it must take the byte in that cycle
// - config: cfg_we_i high writes cfg_inverse_mode_i (0 forward, 1 inverse);
//   write only while the block is idle
// - sequence: the accepting edge loads the byte, then 7 rounds of square then
//   multiply run, then a finish step, then the result register shows the byte
// - requests do not overlap; busy drops as the result appears, so a new
//   request may be taken in the cycle the result is on the ports
// - the single shared gf multiplier gives one product a cycle, walking the
//   exponent 254 by square-and-multiply
// - reset: asynchronous active low, returns the sequencer to idle, clears the
//   result strobe and selects forward mode
// - zero maps to zero in the field inverse, so forward(0x00) is 0x63
// ----------------------------------------------------------------------------
module aes_sbox_byte_compute (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_byte_i,
  input  logic       cfg_we_i,
  input  logic       cfg_inverse_mode_i,
  output logic [7:0] out_byte_o,
  output logic       valid_o
);
  import asbc_pkg::*;

  asbc_cmd_t cmd;
  logic      inverse_mode_q;

  // mode register; the user must change it only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       inverse_mode_q <= 1'b0;
    else if (cfg_we_i) inverse_mode_q <= cfg_inverse_mode_i;
  end

  // sequencer: load, seven square/multiply rounds, finish
  asbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // datapath: affine transforms and the shared field multiplier
  asbc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .inverse_mode_i (inverse_mode_q),
    .in_byte_i      (in_byte_i),
    .out_byte_o     (out_byte_o),
    .valid_o        (valid_o)
  );

endmodule
